// ===== design/lqz_pkg.sv =====
package lqz_pkg;

  // opcodes
  localparam logic [1:0] OP_SHADE = 2'd0;
  localparam logic [1:0] OP_PAL   = 2'd1;
  localparam logic [1:0] OP_LIGHT = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic CFG_PALETTE_COUNT = 1'b0;
  localparam logic CFG_LIGHT_COUNT   = 1'b1;

  localparam logic [6:0] PALETTE_COUNT_RESET = 7'd40;
  localparam logic [3:0] LIGHT_COUNT_RESET   = 4'd5;

  // starting bound of the nearest-color search, squared (300 * 300)
  localparam logic [17:0] NEAR_BOUND_SQ = 18'd90000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] slot;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] radius;
  } item_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== design/lit_palette_quantizer_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  opcode slot pos_x pos_y red green blue radius
// out      output     out_valid/ out_stall out_red out_green out_blue
// cfg      input      cfg_we (no wait)     cfg_index cfg_data
//
// A write transaction is taken by the back end in its idle state. In a shade
// transaction each light, up to the light count after saturation to the table
// depth, runs a bit-serial square root and a bit-serial divide (a zero-radius
// light skips its divide), then the palette RAM is read one entry per cycle,
// up to the palette count after saturation to its table depth. A
// two-entry queue lets the front accept while the back works; the result
// register holds a finished pixel under out_stall while the next one is
// computed. Reset is synchronous and clears control state and the count
// registers (palette 40, lights 5).
module lit_palette_quantizer_top import lqz_pkg::*; #(
  parameter int PALETTE_DEPTH = 64,
  parameter int LIGHT_DEPTH   = 8,
  parameter int FRAC_BITS     = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [5:0] slot,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] radius,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  logic [6:0] palette_count;
  logic [3:0] light_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= PALETTE_COUNT_RESET;
      light_count   <= LIGHT_COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PALETTE_COUNT) palette_count <= cfg_data;
      if (cfg_index == CFG_LIGHT_COUNT)   light_count   <= cfg_data[3:0];
    end
  end

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign in_item = '{opcode: opcode, slot: slot, pos_x: pos_x, pos_y: pos_y,
                     red: red, green: green, blue: blue, radius: radius};

  lqz_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lqz_engine #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .LIGHT_DEPTH   (LIGHT_DEPTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .palette_count (palette_count),
    .light_count   (light_count),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

endmodule

// ===== design/lqz_ram.sv =====
module lqz_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lqz_front.sv =====
module lqz_front import lqz_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  // two-entry queue; opcode 3 is accepted and dropped here
  item_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall &&
                    (in_item.opcode == OP_SHADE || in_item.opcode == OP_PAL ||
                     in_item.opcode == OP_LIGHT);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rptr];
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/lqz_engine.sv =====
module lqz_engine import lqz_pkg::*; #(
  parameter int PALETTE_DEPTH = 64,
  parameter int LIGHT_DEPTH   = 8,
  parameter int FRAC_BITS     = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] palette_count,
  input  logic [3:0] light_count,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam int F        = FRAC_BITS;
  localparam int PI_W     = $clog2(PALETTE_DEPTH);
  localparam int PC_W     = $clog2(PALETTE_DEPTH + 1);
  localparam int LI_W     = (LIGHT_DEPTH > 1) ? $clog2(LIGHT_DEPTH) : 1;
  localparam int LC_W     = $clog2(LIGHT_DEPTH + 1);
  localparam int SQ_STEPS = F + 9;
  localparam int V_W      = 2 * SQ_STEPS;
  localparam int R_W      = SQ_STEPS;
  localparam int SC_W     = $clog2(SQ_STEPS + 1);
  localparam int W_W      = F + 2;
  localparam int SUM_W    = F + $clog2(3 * LIGHT_DEPTH + 1) + 2;
  localparam int CAP_I    = (6 * (1 << F)) / 5;
  localparam logic [F:0] ONE = (F+1)'(1 << F);
  localparam logic [F:0] CAP = CAP_I[F:0];

  typedef enum logic [3:0] {
    S_IDLE, S_LSTART, S_SQRT, S_DIV, S_ACC, S_CLAMP, S_SCALE, S_SEARCH, S_FINISH
  } state_t;

  state_t state;

  logic [7:0]  px, py, pr, pg, pb;
  logic [7:0]  lr, lg, lb;
  logic [7:0]  rad;
  logic [LC_W-1:0] li;
  logic [LC_W-1:0] nl;
  logic [LC_W-1:0] nl_sat;
  logic [V_W-1:0]  sq_v;
  logic [R_W+1:0]  rem;
  logic [R_W-1:0]  root;
  logic [8:0]      drem;
  logic [SC_W-1:0] steps;
  logic signed [SUM_W-1:0] sum;
  logic [F:0]      factor;
  logic [1:0]      ch;
  logic [PC_W-1:0] np;
  logic [PC_W-1:0] issue;
  logic            pend;
  logic [17:0]     best;
  logic [23:0]     chosen;
  logic            out_load;

  // palette memory
  logic            ram_we;
  logic [PI_W-1:0] ram_raddr;
  logic [23:0]     ram_rdata;

  lqz_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PI_W'(q_item.slot)),
    .wdata ({q_item.red, q_item.green, q_item.blue}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // light memory, read address is set in the state just before S_LSTART
  logic            lram_we;
  logic [LI_W-1:0] lram_raddr;
  logic [23:0]     lent;

  lqz_ram #(.WIDTH(24), .DEPTH(LIGHT_DEPTH)) u_lights (
    .clk   (clk),
    .we    (lram_we),
    .waddr (LI_W'(q_item.slot)),
    .wdata ({q_item.pos_x, q_item.pos_y, q_item.radius}),
    .raddr (lram_raddr),
    .rdata (lent)
  );

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign ram_we     = q_pop && (q_item.opcode == OP_PAL) &&
                      (9'(q_item.slot) < 9'(PALETTE_DEPTH));
  assign ram_raddr  = PI_W'(issue);
  assign lram_we    = q_pop && (q_item.opcode == OP_LIGHT) &&
                      (9'(q_item.slot) < 9'(LIGHT_DEPTH));
  assign lram_raddr = (state == S_ACC) ? LI_W'(li + LC_W'(1)) : '0;
  assign nl_sat     = (8'(light_count) > 8'(LIGHT_DEPTH)) ? LC_W'(LIGHT_DEPTH)
                                                          : LC_W'(light_count);
  assign out_load   = (state == S_FINISH) && (!out_valid || !out_stall);

  // light geometry
  logic [7:0]  adx, ady;
  logic [16:0] d2;
  assign adx  = abs_diff(px, lent[23:16]);
  assign ady  = abs_diff(py, lent[15:8]);
  assign d2   = 17'({8'd0, adx} * {8'd0, adx}) + 17'({8'd0, ady} * {8'd0, ady});

  // one square-root step
  logic [R_W+1:0] cand, trial;
  assign cand  = {rem[R_W-1:0], sq_v[V_W-1 -: 2]};
  assign trial = {root, 2'b01};

  // one divide step
  logic [8:0] dcand;
  assign dcand = {drem[7:0], root[R_W-1]};

  // weight of the finished light
  logic [F:0]              ratio;
  logic signed [W_W-1:0]   weight;
  logic signed [SUM_W-1:0] w_ext;
  assign ratio  = (rad == 8'd0 || root > R_W'(CAP)) ? CAP : root[F:0];
  assign weight = $signed({1'b0, ONE}) - $signed({1'b0, ratio});
  assign w_ext  = {{(SUM_W-W_W){weight[W_W-1]}}, weight};

  // channel scaling, one channel per cycle
  logic [7:0]   chan;
  logic [F+8:0] prod;
  always_comb begin
    case (ch)
      2'd0:    chan = pr;
      2'd1:    chan = pg;
      default: chan = pb;
    endcase
  end
  assign prod = (F+9)'({{(F+1){1'b0}}, chan} * {8'd0, factor});

  // palette distance
  logic [7:0]  er, eg, eb;
  logic [17:0] cdist;
  assign er    = abs_diff(ram_rdata[23:16], lr);
  assign eg    = abs_diff(ram_rdata[15:8], lg);
  assign eb    = abs_diff(ram_rdata[7:0], lb);
  assign cdist = 18'({8'd0, er} * {8'd0, er}) + 18'({8'd0, eg} * {8'd0, eg}) +
                 18'({8'd0, eb} * {8'd0, eb});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_item.opcode == OP_SHADE) begin
            px  <= q_item.pos_x;
            py  <= q_item.pos_y;
            pr  <= q_item.red;
            pg  <= q_item.green;
            pb  <= q_item.blue;
            li  <= '0;
            sum <= '0;
            nl  <= nl_sat;
            np  <= (9'(palette_count) > 9'(PALETTE_DEPTH)) ? PC_W'(PALETTE_DEPTH)
                                                           : PC_W'(palette_count);
            state <= (nl_sat != '0) ? S_LSTART : S_CLAMP;
          end
        end
        S_LSTART: begin
          sq_v  <= V_W'({d2, {(2*F){1'b0}}});
          rem   <= '0;
          root  <= '0;
          rad   <= lent[7:0];
          steps <= SC_W'(SQ_STEPS);
          state <= S_SQRT;
        end
        S_SQRT: begin
          sq_v <= sq_v << 2;
          if (cand >= trial) begin
            rem  <= cand - trial;
            root <= {root[R_W-2:0], 1'b1};
          end else begin
            rem  <= cand;
            root <= {root[R_W-2:0], 1'b0};
          end
          if (steps == SC_W'(1)) begin
            drem  <= '0;
            steps <= SC_W'(R_W);
            state <= S_DIV;
          end else begin
            steps <= steps - 1'b1;
          end
        end
        S_DIV: begin
          // quotient shifts into root from the bottom
          if (rad == 8'd0) begin
            state <= S_ACC;
          end else begin
            if (dcand >= {1'b0, rad}) begin
              drem <= dcand - {1'b0, rad};
              root <= {root[R_W-2:0], 1'b1};
            end else begin
              drem <= dcand;
              root <= {root[R_W-2:0], 1'b0};
            end
            if (steps == SC_W'(1)) state <= S_ACC;
            else steps <= steps - 1'b1;
          end
        end
        S_ACC: begin
          // fold three times the finished light's weight, then next light
          sum <= sum + w_ext + (w_ext <<< 1);
          li  <= li + LC_W'(1);
          if (li + LC_W'(1) < nl) state <= S_LSTART;
          else state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (sum[SUM_W-1])
            factor <= '0;
          else if (sum > $signed(SUM_W'(ONE)))
            factor <= ONE;
          else
            factor <= sum[F:0];
          ch    <= 2'd0;
          state <= S_SCALE;
        end
        S_SCALE: begin
          case (ch)
            2'd0:    lr <= prod[F+7:F];
            2'd1:    lg <= prod[F+7:F];
            default: lb <= prod[F+7:F];
          endcase
          ch <= ch + 2'd1;
          if (ch == 2'd2) begin
            issue  <= '0;
            pend   <= 1'b0;
            best   <= NEAR_BOUND_SQ;
            chosen <= '0;
            state  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (issue < np) begin
            issue <= issue + 1'b1;
            pend  <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && cdist < best) begin
            best   <= cdist;
            chosen <= ram_rdata;
          end
          if (issue == np && !pend) state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_red   <= chosen[23:16];
            out_green <= chosen[15:8];
            out_blue  <= chosen[7:0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
